// File: rtl/core/gbnp_pkg.sv
package gbnp_pkg;

   localparam int COORD_W  = 10;
   localparam int ID_W     = 16;
   localparam int STATUS_W = 3;
   localparam int CFG_W    = 7;
   localparam int CX_W     = 9;
   localparam int RECIP_SH = 20;

   localparam int CELL_EDGE_DEF    = 16;
   localparam int MAX_ACROSS_DEF   = 64;
   localparam int MAX_DOWN_DEF     = 64;
   localparam int BUCKET_DEPTH_DEF = 8;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_FOUND    = 3'd1,
      ST_NONE     = 3'd2,
      ST_OUTSIDE  = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic {
      FN_INSERT = 1'b0,
      FN_QUERY  = 1'b1
   } func_type;

   typedef enum logic {
      CSR_WIDE = 1'b0,
      CSR_HIGH = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic                func;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [ID_W-1:0]     id;
      logic [CX_W-1:0]     cx;
      logic [CX_W-1:0]     cy;
      logic                in_grid;
   } job_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_INS_RD,
      BK_INS_CHK,
      BK_Q_CELL,
      BK_Q_FILL,
      BK_Q_PT,
      BK_Q_END,
      BK_DONE
   } bk_state_type;

endpackage

// File: rtl/core/gbnp_queue.sv
module gbnp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gbnp_pkg::job_type data_in,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output gbnp_pkg::job_type data_out
);

   gbnp_pkg::job_type slot_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign data_out = slot_ff[rp_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= data_in;
      end
   end

endmodule

// File: rtl/core/gbnp_front.sv
module gbnp_front #(
   parameter int CELL_EDGE  = gbnp_pkg::CELL_EDGE_DEF,
   parameter int MAX_ACROSS = gbnp_pkg::MAX_ACROSS_DEF,
   parameter int MAX_DOWN   = gbnp_pkg::MAX_DOWN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_func,
   input  logic [gbnp_pkg::COORD_W-1:0] req_coord_x,
   input  logic [gbnp_pkg::COORD_W-1:0] req_coord_y,
   input  logic [gbnp_pkg::ID_W-1:0]    req_point_id,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [gbnp_pkg::CFG_W-1:0]   csr_wdata,
   input  logic                         hold,
   output logic [gbnp_pkg::CFG_W-1:0]   cells_wide,
   output logic [gbnp_pkg::CFG_W-1:0]   cells_high,
   input  logic                         q_full,
   output logic                         q_push,
   output gbnp_pkg::job_type            q_data
);

   localparam int RECIP  = ((1 << gbnp_pkg::RECIP_SH) + CELL_EDGE - 1) / CELL_EDGE;
   localparam int PROD_W = gbnp_pkg::COORD_W + gbnp_pkg::RECIP_SH;

   logic [gbnp_pkg::CFG_W-1:0]   wide_ff, wide_in;
   logic [gbnp_pkg::CFG_W-1:0]   high_ff, high_in;
   logic                         vld_ff, vld_in;
   logic                         func_ff;
   logic [gbnp_pkg::COORD_W-1:0] x_ff, y_ff;
   logic [gbnp_pkg::ID_W-1:0]    id_ff;
   logic [gbnp_pkg::CX_W-1:0]    cx_ff, cy_ff, cx_in, cy_in;
   logic [PROD_W-1:0]            prod_x, prod_y;
   logic                         accept;

   assign req_full   = hold || (vld_ff && q_full);
   assign accept     = req_push && !req_full;
   assign q_push     = vld_ff && !q_full;
   assign cells_wide = wide_ff;
   assign cells_high = high_ff;

   // divide by the cell edge through a reciprocal, exact for 10-bit coordinates
   always_comb begin
      prod_x = PROD_W'(req_coord_x) * PROD_W'(RECIP);
      prod_y = PROD_W'(req_coord_y) * PROD_W'(RECIP);
      cx_in  = prod_x[gbnp_pkg::RECIP_SH +: gbnp_pkg::CX_W];
      cy_in  = prod_y[gbnp_pkg::RECIP_SH +: gbnp_pkg::CX_W];
      vld_in = accept ? 1'b1 : (q_push ? 1'b0 : vld_ff);
      wide_in = wide_ff;
      high_in = high_ff;
      if (csr_we) begin
         if (csr_index == gbnp_pkg::CSR_WIDE) begin
            wide_in = csr_wdata;
         end else begin
            high_in = csr_wdata;
         end
      end
   end

   always_comb begin
      q_data.func    = func_ff;
      q_data.x       = x_ff;
      q_data.y       = y_ff;
      q_data.id      = id_ff;
      q_data.cx      = cx_ff;
      q_data.cy      = cy_ff;
      q_data.in_grid = (32'(cx_ff) < 32'(wide_ff)) && (32'(cx_ff) < MAX_ACROSS) &&
                       (32'(cy_ff) < 32'(high_ff)) && (32'(cy_ff) < MAX_DOWN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= 1'b0;
         wide_ff <= gbnp_pkg::CFG_W'(64);
         high_ff <= gbnp_pkg::CFG_W'(64);
      end else begin
         vld_ff  <= vld_in;
         wide_ff <= wide_in;
         high_ff <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         x_ff    <= req_coord_x;
         y_ff    <= req_coord_y;
         id_ff   <= req_point_id;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
      end
   end

endmodule

// File: rtl/core/gbnp_back.sv
module gbnp_back #(
   parameter int CELL_EDGE    = gbnp_pkg::CELL_EDGE_DEF,
   parameter int MAX_ACROSS   = gbnp_pkg::MAX_ACROSS_DEF,
   parameter int MAX_DOWN     = gbnp_pkg::MAX_DOWN_DEF,
   parameter int BUCKET_DEPTH = gbnp_pkg::BUCKET_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  gbnp_pkg::job_type             q_data,
   input  logic [gbnp_pkg::CFG_W-1:0]    cells_wide,
   input  logic [gbnp_pkg::CFG_W-1:0]    cells_high,
   output logic                          hold,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [gbnp_pkg::STATUS_W-1:0] rsp_status,
   output logic [gbnp_pkg::ID_W-1:0]     rsp_nearest_id
);

   localparam int CELLS    = MAX_ACROSS * MAX_DOWN;
   localparam int CELL_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int PT_DEPTH = CELLS * BUCKET_DEPTH;
   localparam int PT_W     = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
   localparam int FW       = $clog2(BUCKET_DEPTH + 1);
   localparam int DW       = $clog2(CELL_EDGE);
   localparam int D2_W     = 2 * DW + 1;
   localparam int BEST_W   = $clog2(CELL_EDGE * CELL_EDGE + 1);
   localparam int NW       = gbnp_pkg::CX_W + 1;
   localparam int CW       = gbnp_pkg::COORD_W;
   localparam int PTD_W    = 2 * CW + gbnp_pkg::ID_W;

   gbnp_pkg::bk_state_type state_ff, state_in;
   gbnp_pkg::job_type      job_ff, job_in;

   logic [FW-1:0]       fill_mem [CELLS];
   logic [PTD_W-1:0]    pt_mem [PT_DEPTH];
   logic [FW-1:0]       fill_q_ff;
   logic [PTD_W-1:0]    pt_q_ff;

   logic                clr_ff, clr_in;
   logic [CELL_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic [1:0]          di_ff, di_in, dj_ff, dj_in;
   logic [FW-1:0]       cnt_ff, cnt_in, lim_ff, lim_in;
   logic [CELL_W-1:0]   cell_ff, cell_in;
   logic                pv_ff, pv_in;
   logic [BEST_W-1:0]   best_ff, best_in;
   logic [gbnp_pkg::ID_W-1:0] best_id_ff, best_id_in;
   logic                hit_ff, hit_in;
   logic [gbnp_pkg::STATUS_W-1:0] res_ff, res_in;
   logic                out_vld_ff, out_vld_in;
   logic [gbnp_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [gbnp_pkg::ID_W-1:0] out_id_ff, out_id_in;

   logic                fill_we;
   logic [CELL_W-1:0]   fill_waddr, fill_raddr;
   logic [FW-1:0]       fill_wdata;
   logic                pt_we;
   logic [PT_W-1:0]     pt_waddr, pt_raddr;
   logic [PTD_W-1:0]    pt_wdata;

   logic [NW-1:0]       ni, nj;
   logic                nb_inside;
   logic [CELL_W-1:0]   nb_cell, ins_cell;
   logic [CW-1:0]       px, py, dx, dy;
   logic [DW-1:0]       dxs, dys;
   logic [D2_W-1:0]     d2;
   logic                advance_last;

   assign hold           = clr_ff;
   assign rsp_empty      = !out_vld_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_nearest_id = out_id_ff;

   // below-zero neighbours wrap to a large value and fail the bound check
   always_comb begin
      ni = NW'(job_ff.cx) + NW'(di_ff) - NW'(1);
      nj = NW'(job_ff.cy) + NW'(dj_ff) - NW'(1);
      nb_inside = (32'(ni) < 32'(cells_wide)) && (32'(ni) < MAX_ACROSS) &&
                  (32'(nj) < 32'(cells_high)) && (32'(nj) < MAX_DOWN);
      nb_cell  = CELL_W'(32'(nj) * MAX_ACROSS + 32'(ni));
      ins_cell = CELL_W'(32'(job_ff.cy) * MAX_ACROSS + 32'(job_ff.cx));
      advance_last = (di_ff == 2'd2) && (dj_ff == 2'd2);
   end

   always_comb begin
      px  = pt_q_ff[PTD_W-1 -: CW];
      py  = pt_q_ff[PTD_W-1-CW -: CW];
      dx  = (job_ff.x > px) ? (job_ff.x - px) : (px - job_ff.x);
      dy  = (job_ff.y > py) ? (job_ff.y - py) : (py - job_ff.y);
      dxs = dx[DW-1:0];
      dys = dy[DW-1:0];
      d2  = D2_W'(dxs) * D2_W'(dxs) + D2_W'(dys) * D2_W'(dys);
   end

   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      q_pop         = 1'b0;
      clr_in        = clr_ff;
      clr_cnt_in    = clr_cnt_ff;
      di_in         = di_ff;
      dj_in         = dj_ff;
      cnt_in        = cnt_ff;
      lim_in        = lim_ff;
      cell_in       = cell_ff;
      pv_in         = 1'b0;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      hit_in        = hit_ff;
      res_in        = res_ff;
      out_vld_in    = out_vld_ff && !rsp_pop;
      out_status_in = out_status_ff;
      out_id_in     = out_id_ff;
      fill_we       = 1'b0;
      fill_waddr    = ins_cell;
      fill_wdata    = fill_q_ff + FW'(1);
      fill_raddr    = ins_cell;
      pt_we         = 1'b0;
      pt_waddr      = PT_W'(32'(ins_cell) * BUCKET_DEPTH + 32'(fill_q_ff));
      pt_wdata      = {job_ff.x, job_ff.y, job_ff.id};
      pt_raddr      = PT_W'(32'(cell_ff) * BUCKET_DEPTH + 32'(cnt_ff));

      if (clr_ff) begin
         fill_we    = 1'b1;
         fill_waddr = clr_cnt_ff;
         fill_wdata = '0;
         clr_cnt_in = clr_cnt_ff + CELL_W'(1);
         if (clr_cnt_ff == CELL_W'(CELLS - 1)) begin
            clr_in = 1'b0;
         end
      end

      if (pv_ff && (32'(dx) < CELL_EDGE) && (32'(dy) < CELL_EDGE) &&
          (32'(d2) < 32'(best_ff))) begin
         best_in    = BEST_W'(d2);
         best_id_in = pt_q_ff[gbnp_pkg::ID_W-1:0];
         hit_in     = 1'b1;
      end

      case (state_ff)
         gbnp_pkg::BK_IDLE: begin
            if (!clr_ff && !q_empty) begin
               q_pop   = 1'b1;
               job_in  = q_data;
               best_in = BEST_W'(CELL_EDGE * CELL_EDGE);
               hit_in  = 1'b0;
               di_in   = 2'd0;
               dj_in   = 2'd0;
               if (q_data.func == gbnp_pkg::FN_QUERY) begin
                  state_in = gbnp_pkg::BK_Q_CELL;
               end else if (!q_data.in_grid) begin
                  res_in   = gbnp_pkg::ST_OUTSIDE;
                  state_in = gbnp_pkg::BK_DONE;
               end else begin
                  state_in = gbnp_pkg::BK_INS_RD;
               end
            end
         end
         gbnp_pkg::BK_INS_RD: begin
            state_in = gbnp_pkg::BK_INS_CHK;
         end
         gbnp_pkg::BK_INS_CHK: begin
            if (32'(fill_q_ff) >= BUCKET_DEPTH) begin
               res_in = gbnp_pkg::ST_FULL;
            end else begin
               pt_we   = 1'b1;
               fill_we = 1'b1;
               res_in  = gbnp_pkg::ST_INSERTED;
            end
            state_in = gbnp_pkg::BK_DONE;
         end
         gbnp_pkg::BK_Q_CELL: begin
            if (nb_inside) begin
               fill_raddr = nb_cell;
               cell_in    = nb_cell;
               state_in   = gbnp_pkg::BK_Q_FILL;
            end else if (advance_last) begin
               state_in = gbnp_pkg::BK_Q_END;
            end else begin
               di_in = (dj_ff == 2'd2) ? di_ff + 2'd1 : di_ff;
               dj_in = (dj_ff == 2'd2) ? 2'd0 : dj_ff + 2'd1;
            end
         end
         gbnp_pkg::BK_Q_FILL: begin
            lim_in = fill_q_ff;
            cnt_in = '0;
            if (fill_q_ff != '0) begin
               state_in = gbnp_pkg::BK_Q_PT;
            end else if (advance_last) begin
               state_in = gbnp_pkg::BK_Q_END;
            end else begin
               di_in    = (dj_ff == 2'd2) ? di_ff + 2'd1 : di_ff;
               dj_in    = (dj_ff == 2'd2) ? 2'd0 : dj_ff + 2'd1;
               state_in = gbnp_pkg::BK_Q_CELL;
            end
         end
         gbnp_pkg::BK_Q_PT: begin
            pv_in  = 1'b1;
            cnt_in = cnt_ff + FW'(1);
            if (cnt_ff + FW'(1) == lim_ff) begin
               if (advance_last) begin
                  state_in = gbnp_pkg::BK_Q_END;
               end else begin
                  di_in    = (dj_ff == 2'd2) ? di_ff + 2'd1 : di_ff;
                  dj_in    = (dj_ff == 2'd2) ? 2'd0 : dj_ff + 2'd1;
                  state_in = gbnp_pkg::BK_Q_CELL;
               end
            end
         end
         gbnp_pkg::BK_Q_END: begin
            state_in = gbnp_pkg::BK_DONE;
         end
         gbnp_pkg::BK_DONE: begin
            if (!out_vld_ff || rsp_pop) begin
               out_vld_in = 1'b1;
               if (job_ff.func == gbnp_pkg::FN_QUERY) begin
                  out_status_in = hit_ff ? gbnp_pkg::ST_FOUND : gbnp_pkg::ST_NONE;
                  out_id_in     = hit_ff ? best_id_ff : '0;
               end else begin
                  out_status_in = res_ff;
                  out_id_in     = '0;
               end
               state_in = gbnp_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = gbnp_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gbnp_pkg::BK_IDLE;
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         pv_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_cnt_ff <= clr_cnt_in;
         pv_ff      <= pv_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_in;
      di_ff         <= di_in;
      dj_ff         <= dj_in;
      cnt_ff        <= cnt_in;
      lim_ff        <= lim_in;
      cell_ff       <= cell_in;
      best_ff       <= best_in;
      best_id_ff    <= best_id_in;
      hit_ff        <= hit_in;
      res_ff        <= res_in;
      out_status_ff <= out_status_in;
      out_id_ff     <= out_id_in;
   end

   always_ff @(posedge clock) begin
      if (fill_we) begin
         fill_mem[fill_waddr] <= fill_wdata;
      end
      fill_q_ff <= fill_mem[fill_raddr];
   end

   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[pt_waddr] <= pt_wdata;
      end
      pt_q_ff <= pt_mem[pt_raddr];
   end

endmodule

// File: rtl/core/grid_bucket_nearest_point.sv
// Uniform-grid point store with nearest point query.
// Input queue: req_push / req_full carry one transaction of func, coord_x,
// coord_y and point_id. func insert appends the point to its cell bucket;
// func query searches the 3x3 cells around its position.
// Result queue: rsp_empty / rsp_pop; one transaction of status and
// nearest_id per input, in input order.
// csr_we / csr_index / csr_wdata set grid width and height; write only idle.
// Insert steps: read the cell fill count, check it, then write the point;
// a point outside the grid goes straight to its result. A query visits each
// neighbour cell inside the grid, reads its fill count and scans its stored
// points. One item is in the back end at a time; the fill count and point
// memories, one read per cycle, set the query time. A two-entry queue lets new items wait.
// Reset: the bucket fill memory is cleared one cell per cycle, over all
// MAX_CELLS_ACROSS * MAX_CELLS_DOWN cells (4096 by default); req_full stays
// high until done. Stored points need no clearing.
// When rsp_pop stays low the result holds, the back end stops at its next
// result and the input queue fills, then req_full rises.
module grid_bucket_nearest_point #(
   parameter int CELL_EDGE        = gbnp_pkg::CELL_EDGE_DEF,
   parameter int MAX_CELLS_ACROSS = gbnp_pkg::MAX_ACROSS_DEF,
   parameter int MAX_CELLS_DOWN   = gbnp_pkg::MAX_DOWN_DEF,
   parameter int BUCKET_DEPTH     = gbnp_pkg::BUCKET_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_func,
   input  logic [gbnp_pkg::COORD_W-1:0]  req_coord_x,
   input  logic [gbnp_pkg::COORD_W-1:0]  req_coord_y,
   input  logic [gbnp_pkg::ID_W-1:0]     req_point_id,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [gbnp_pkg::STATUS_W-1:0] rsp_status,
   output logic [gbnp_pkg::ID_W-1:0]     rsp_nearest_id,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [gbnp_pkg::CFG_W-1:0]    csr_wdata
);

   logic                       hold;
   logic                       q_push, q_full, q_pop, q_empty;
   gbnp_pkg::job_type          q_in, q_out;
   logic [gbnp_pkg::CFG_W-1:0] cells_wide, cells_high;

   gbnp_front #(
      .CELL_EDGE  (CELL_EDGE),
      .MAX_ACROSS (MAX_CELLS_ACROSS),
      .MAX_DOWN   (MAX_CELLS_DOWN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_func     (req_func),
      .req_coord_x  (req_coord_x),
      .req_coord_y  (req_coord_y),
      .req_point_id (req_point_id),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .hold         (hold),
      .cells_wide   (cells_wide),
      .cells_high   (cells_high),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   gbnp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .data_in  (q_in),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (q_out)
   );

   gbnp_back #(
      .CELL_EDGE    (CELL_EDGE),
      .MAX_ACROSS   (MAX_CELLS_ACROSS),
      .MAX_DOWN     (MAX_CELLS_DOWN),
      .BUCKET_DEPTH (BUCKET_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .q_data         (q_out),
      .cells_wide     (cells_wide),
      .cells_high     (cells_high),
      .hold           (hold),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_nearest_id (rsp_nearest_id)
   );

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      hold |-> req_full)
      else $error("input accepted during clearing pass");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_status <= gbnp_pkg::STATUS_W'(gbnp_pkg::ST_FULL)))
      else $error("illegal status");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status != gbnp_pkg::STATUS_W'(gbnp_pkg::ST_FOUND)))
      |-> (rsp_nearest_id == '0))
      else $error("nearest_id set without a hit");

endmodule
